// ===== src/ppi_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppi_pkg: shared types and constants
// Field widths, table sizes, operation codes, controller states and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ppi_pkg;

  // table sizes and fixed-point format
  localparam int MAX_KNOTS = 64;
  localparam int MAX_ORDER = 3;
  localparam int FRAC_BITS = 16;
  localparam int ROW_LEN   = MAX_ORDER + 1;

  // payload field widths
  localparam int MODE_W   = 2;
  localparam int ROW_W    = 6;
  localparam int CSLOT_W  = 2;
  localparam int DATA_W   = 32;

  // configuration port
  localparam int KCNT_W     = 7;
  localparam int ORDER_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_KNOT_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_POLY_ORDER = CFG_IDX_W'(1);

  // derived internal widths
  localparam int KIDX_W  = $clog2(MAX_KNOTS);
  localparam int CNT_W   = $clog2(MAX_KNOTS + 1);
  localparam int SLOT_W  = $clog2(ROW_LEN);
  localparam int CADDR_W = $clog2(MAX_KNOTS * ROW_LEN);
  localparam int DIFF_W  = DATA_W + 1;
  localparam int PROD_W  = DATA_W + DIFF_W;
  localparam int SUM_W   = PROD_W + 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_KNOT  = 2'd0,
    MODE_COEFF = 2'd1,
    MODE_EVAL  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    KSEL_FIRST,
    KSEL_LAST,
    KSEL_MID,
    KSEL_BOT
  } ksel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_FIRST,
    S_RD_LAST,
    S_CHK,
    S_SRCH,
    S_SCMP,
    S_DIFF,
    S_ACC,
    S_MUL,
    S_ADD,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic  capture;
    logic  knot_rd;
    ksel_t knot_sel;
    logic  lo_chk;
    logic  range_chk;
    logic  srch_init;
    logic  srch_step;
    logic  diff_ld;
    logic  coeff_rd;
    logic  coeff_first;
    logic  acc_init;
    logic  mul;
    logic  add;
    logic  emit;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              oor;
    logic              top_gt1;
    logic              horner_done;
    logic              out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== src/ppi_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppi_in_if: request channel
// Valid/ready channel carrying one table write or one query per beat.
// ----------------------------------------------------------------------------
interface ppi_in_if;
  import ppi_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic [ROW_W-1:0]         row_index;
  logic [CSLOT_W-1:0]       coeff_slot;
  logic signed [DATA_W-1:0] data_value;

  modport source (output valid, mode, row_index, coeff_slot, data_value, input ready);
  modport sink   (input valid, mode, row_index, coeff_slot, data_value, output ready);
endinterface
`default_nettype wire

// ===== src/ppi_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppi_out_if: result channel
// Valid/ready channel carrying one interpolated value per beat.
// ----------------------------------------------------------------------------
interface ppi_out_if;
  import ppi_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] interp_value;
  logic                     out_of_range;

  modport source (output valid, interp_value, out_of_range, input ready);
  modport sink   (input valid, interp_value, out_of_range, output ready);
endinterface
`default_nettype wire

// ===== src/piecewise_poly_interpolator.sv =====
`default_nettype none
// Table writes: write beats are accepted in the idle state and may follow back to back.
// Query: after the accept beat the sequencer reads the first and last knots, checks the range,
//   runs the binary knot search and then the Horner steps; an out-of-range query goes straight to emit.
// Flow: no new beat is accepted until the current query has been emitted; the knot
//   search uses the single-port knot table (read then compare) and the shared multiply/add unit.
// Reset: rst_n synchronous, active low; knot_count = 1, poly_order = 3.
// ----------------------------------------------------------------------------
// piecewise_poly_interpolator: Q16.16 piecewise polynomial lookup
// Knot and coefficient tables written through the request channel; queries
// run a binary knot search and a Horner evaluation with saturation.
// ----------------------------------------------------------------------------
module piecewise_poly_interpolator (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  ppi_in_if.sink                                 in_ch,
  ppi_out_if.source                              out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [ppi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ppi_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import ppi_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Controller: accepts a beat only when idle. Write beats update a table
  // on the accept edge; query beats start the search/evaluate sequence.
  ppi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: tables, config, search window, Horner unit, result register.
  // The result register lets the next beat in while a result waits.
  ppi_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_mode          (in_ch.mode),
    .in_row_index     (in_ch.row_index),
    .in_coeff_slot    (in_ch.coeff_slot),
    .in_data_value    (in_ch.data_value),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_interp_value (out_ch.interp_value),
    .out_of_range     (out_ch.out_of_range)
  );

endmodule
`default_nettype wire

// ===== src/ppi_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppi_ctrl: sequencer
// Steps one query through range check, knot search and Horner evaluation.
// ----------------------------------------------------------------------------
module ppi_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ppi_pkg::sts_t sts,
  output ppi_pkg::cmd_t      cmd
);
  import ppi_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (sts.mode == MODE_EVAL) state_nxt = S_RD_FIRST;
        end
      end
      S_RD_FIRST: begin
        cmd.knot_rd  = 1'b1;
        cmd.knot_sel = KSEL_FIRST;
        state_nxt    = S_RD_LAST;
      end
      S_RD_LAST: begin
        cmd.lo_chk   = 1'b1;
        cmd.knot_rd  = 1'b1;
        cmd.knot_sel = KSEL_LAST;
        state_nxt    = S_CHK;
      end
      S_CHK: begin
        cmd.range_chk = 1'b1;
        cmd.srch_init = 1'b1;
        state_nxt     = sts.oor ? S_EMIT : S_SRCH;
      end
      S_SRCH: begin
        cmd.knot_rd = 1'b1;
        if (sts.top_gt1) begin
          cmd.knot_sel = KSEL_MID;
          state_nxt    = S_SCMP;
        end else begin
          cmd.knot_sel = KSEL_BOT;
          state_nxt    = S_DIFF;
        end
      end
      S_SCMP: begin
        cmd.srch_step = 1'b1;
        state_nxt     = S_SRCH;
      end
      S_DIFF: begin
        cmd.diff_ld     = 1'b1;
        cmd.coeff_rd    = 1'b1;
        cmd.coeff_first = 1'b1;
        state_nxt       = S_ACC;
      end
      S_ACC: begin
        cmd.acc_init = 1'b1;
        if (sts.horner_done) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.coeff_rd = 1'b1;
          state_nxt    = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.add = 1'b1;
        if (sts.horner_done) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.coeff_rd = 1'b1;
          state_nxt    = S_MUL;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== src/ppi_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppi_datapath: tables, search registers and Horner unit
// Knot and coefficient memories, config registers, search window, one
// multiplier and one saturating adder, and the result register.
// ----------------------------------------------------------------------------
module ppi_datapath (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire ppi_pkg::cmd_t                            cmd,
  output ppi_pkg::sts_t                                 sts,
  input  wire logic [ppi_pkg::MODE_W-1:0]               in_mode,
  input  wire logic [ppi_pkg::ROW_W-1:0]                in_row_index,
  input  wire logic [ppi_pkg::CSLOT_W-1:0]              in_coeff_slot,
  input  wire logic signed [ppi_pkg::DATA_W-1:0]        in_data_value,
  input  wire logic                                     cfg_we,
  input  wire logic [ppi_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  wire logic [ppi_pkg::CFG_DATA_W-1:0]           cfg_wdata,
  output logic                                          out_valid,
  input  wire logic                                     out_ready,
  output logic signed [ppi_pkg::DATA_W-1:0]             out_interp_value,
  output logic                                          out_of_range
);
  import ppi_pkg::*;

  // config
  logic [KCNT_W-1:0]  knot_count_r;
  logic [ORDER_W-1:0] poly_order_r;
  logic [CNT_W-1:0]   n_eff;
  logic [SLOT_W-1:0]  order_eff;

  // tables
  logic signed [DATA_W-1:0] knot_mem  [MAX_KNOTS];
  logic signed [DATA_W-1:0] coeff_mem [MAX_KNOTS*ROW_LEN];
  logic signed [DATA_W-1:0] knot_rd_r;
  logic signed [DATA_W-1:0] coeff_rd_r;
  logic                     knot_we;
  logic                     coeff_we;
  logic [KIDX_W-1:0]        knot_waddr;
  logic [CADDR_W-1:0]       coeff_waddr;
  logic [KIDX_W-1:0]        knot_raddr;
  logic [CADDR_W-1:0]       coeff_raddr;

  // query and search
  logic signed [DATA_W-1:0] val_r;
  logic                     lo_fail_r;
  logic                     oor_r;
  logic                     hi_fail;
  logic [KIDX_W-1:0]        bot_r;
  logic [CNT_W-1:0]         top_r;
  logic [CNT_W-1:0]         mid;

  // Horner
  logic [SLOT_W-1:0]        slot_r;
  logic [SLOT_W-1:0]        slot_sel;
  logic signed [DIFF_W-1:0] d_r;
  logic signed [DATA_W-1:0] acc_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] shifted;
  logic signed [SUM_W-1:0]  sum;
  logic signed [DATA_W-1:0] sat;

  // result
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_value_r;
  logic                     out_oor_r;

  // ---- config registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      knot_count_r <= KCNT_W'(1);
      poly_order_r <= ORDER_W'(3);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KNOT_COUNT: knot_count_r <= cfg_wdata[KCNT_W-1:0];
        CFG_POLY_ORDER: poly_order_r <= cfg_wdata[ORDER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (knot_count_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (int'(knot_count_r) > MAX_KNOTS) begin
      n_eff = CNT_W'(MAX_KNOTS);
    end else begin
      n_eff = CNT_W'(knot_count_r);
    end
    if (int'(poly_order_r) > MAX_ORDER) begin
      order_eff = SLOT_W'(MAX_ORDER);
    end else begin
      order_eff = SLOT_W'(poly_order_r);
    end
  end

  // ---- table writes on accepted write beats ----
  assign knot_we  = cmd.capture && (in_mode == MODE_KNOT) && (int'(in_row_index) < MAX_KNOTS);
  assign coeff_we = cmd.capture && (in_mode == MODE_COEFF) &&
                    (int'(in_row_index) < MAX_KNOTS) && (int'(in_coeff_slot) <= MAX_ORDER);
  assign knot_waddr  = KIDX_W'(in_row_index);
  assign coeff_waddr = CADDR_W'(CADDR_W'(in_row_index) * CADDR_W'(ROW_LEN)
                                + CADDR_W'(in_coeff_slot));

  // ---- read addresses ----
  assign mid = top_r >> 1;

  always_comb begin
    case (cmd.knot_sel)
      KSEL_FIRST: knot_raddr = '0;
      KSEL_LAST:  knot_raddr = KIDX_W'(n_eff - CNT_W'(1));
      KSEL_MID:   knot_raddr = KIDX_W'(CNT_W'(bot_r) + mid);
      KSEL_BOT:   knot_raddr = bot_r;
      default:    knot_raddr = bot_r;
    endcase
  end

  assign slot_sel    = cmd.coeff_first ? '0 : SLOT_W'(slot_r + SLOT_W'(1));
  assign coeff_raddr = CADDR_W'(CADDR_W'(bot_r) * CADDR_W'(ROW_LEN) + CADDR_W'(slot_sel));

  always_ff @(posedge clk) begin
    if (knot_we) knot_mem[knot_waddr] <= in_data_value;
    if (cmd.knot_rd) knot_rd_r <= knot_mem[knot_raddr];
  end

  always_ff @(posedge clk) begin
    if (coeff_we) coeff_mem[coeff_waddr] <= in_data_value;
    if (cmd.coeff_rd) coeff_rd_r <= coeff_mem[coeff_raddr];
  end

  // ---- range check and search window ----
  assign hi_fail = val_r > knot_rd_r;

  always_ff @(posedge clk) begin
    if (cmd.capture)   val_r     <= in_data_value;
    if (cmd.lo_chk)    lo_fail_r <= val_r < knot_rd_r;
    if (cmd.range_chk) oor_r     <= lo_fail_r | hi_fail;
    if (cmd.srch_init) begin
      bot_r <= '0;
      top_r <= n_eff;
    end else if (cmd.srch_step) begin
      if (val_r >= knot_rd_r) bot_r <= KIDX_W'(CNT_W'(bot_r) + mid);
      top_r <= top_r - mid;
    end
  end

  // ---- Horner step: acc = sat32(floor(acc * d >> FRAC_BITS) + c) ----
  assign shifted = prod_r >>> FRAC_BITS;
  assign sum     = SUM_W'(shifted) + SUM_W'(coeff_rd_r);

  always_comb begin
    if (sum[SUM_W-1:DATA_W-1] == '0 || sum[SUM_W-1:DATA_W-1] == '1) begin
      sat = sum[DATA_W-1:0];
    end else if (sum[SUM_W-1]) begin
      sat = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.diff_ld)  d_r    <= DIFF_W'(val_r) - DIFF_W'(knot_rd_r);
    if (cmd.coeff_rd) slot_r <= slot_sel;
    if (cmd.mul)      prod_r <= acc_r * d_r;
    if (cmd.acc_init) begin
      acc_r <= coeff_rd_r;
    end else if (cmd.add) begin
      acc_r <= sat;
    end
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_value_r <= oor_r ? '0 : acc_r;
      out_oor_r   <= oor_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_interp_value = out_value_r;
  assign out_of_range     = out_oor_r;

  // ---- status ----
  assign sts.mode        = in_mode;
  assign sts.oor         = lo_fail_r | hi_fail;
  assign sts.top_gt1     = top_r > CNT_W'(1);
  assign sts.horner_done = slot_r == order_eff;
  assign sts.out_free    = !out_valid_r || out_ready;

endmodule
`default_nettype wire

// ===== test/ppi_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppi_checker: result predictor and scoreboard for the spline interpolator
// Tracks the knot and coefficient tables and both registers from the observed
// beats, predicts each query result and compares it with the result channel.
// ----------------------------------------------------------------------------
module ppi_checker
  import ppi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  ppi_in_if                     in_mon,
  ppi_out_if                    out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatch_count,
  output int                    outstanding
);

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     oor;
  } interp_result_t;

  logic signed [DATA_W-1:0] knot_tbl  [MAX_KNOTS];
  logic signed [DATA_W-1:0] coeff_tbl [MAX_KNOTS][ROW_LEN];
  logic [KCNT_W-1:0]        knots_cfg;
  logic [ORDER_W-1:0]       order_cfg;
  interp_result_t           pending_interp [$];

  initial begin
    mismatch_count = 0;
    outstanding    = 0;
  end

  function automatic interp_result_t evaluate_spline(logic signed [DATA_W-1:0] query);
    interp_result_t res;
    int     n, order, base, span, step;
    longint acc, delta, total;
    n     = int'(knots_cfg);
    n     = (n < 1) ? 1 : (n > MAX_KNOTS) ? MAX_KNOTS : n;
    order = (int'(order_cfg) > MAX_ORDER) ? MAX_ORDER : int'(order_cfg);
    res.value = '0;
    res.oor   = 1'b1;
    if (query < knot_tbl[0] || query > knot_tbl[n-1])
      return res;
    // monobound search: last knot not above the query
    base = 0;
    span = n;
    while (span > 1) begin
      step = span / 2;
      if (query >= knot_tbl[base+step])
        base += step;
      span -= step;
    end
    // offset is 33 bits wide and may go negative on unsorted knots
    delta = longint'(query) - longint'(knot_tbl[base]);
    acc   = longint'(coeff_tbl[base][0]);
    for (int i = 1; i <= order; i++) begin
      total = ((acc * delta) >>> FRAC_BITS) + longint'(coeff_tbl[base][i]);
      if (total > 64'sd2147483647)
        acc = 64'sd2147483647;
      else if (total < -64'sd2147483648)
        acc = -64'sd2147483648;
      else
        acc = total;
    end
    res.value = acc[DATA_W-1:0];
    res.oor   = 1'b0;
    return res;
  endfunction

  always @(posedge clk) begin : scoreboard
    interp_result_t want;
    if (!rst_n) begin
      knots_cfg = KCNT_W'(1);
      order_cfg = ORDER_W'(3);
      pending_interp.delete();
    end else begin
      // results first: a result never belongs to a query accepted on the same edge
      if (out_mon.valid && out_mon.ready) begin
        if (pending_interp.size() == 0) begin
          mismatch_count++;
          $error("result beat with no query waiting: interp_value %0d out_of_range %0b",
                 $signed(out_mon.interp_value), out_mon.out_of_range);
        end else begin
          want = pending_interp.pop_front();
          if (out_mon.interp_value !== want.value) begin
            mismatch_count++;
            $error("interp_value mismatch: expected %0d, actual %0d",
                   $signed(want.value), $signed(out_mon.interp_value));
          end
          if (out_mon.out_of_range !== want.oor) begin
            mismatch_count++;
            $error("out_of_range mismatch: expected %0b, actual %0b",
                   want.oor, out_mon.out_of_range);
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_KNOT_COUNT)
          knots_cfg = cfg_wdata[KCNT_W-1:0];
        else if (cfg_index == CFG_POLY_ORDER)
          order_cfg = cfg_wdata[ORDER_W-1:0];
      end
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.mode)
          MODE_KNOT:  knot_tbl[in_mon.row_index] = in_mon.data_value;
          MODE_COEFF: coeff_tbl[in_mon.row_index][in_mon.coeff_slot] = in_mon.data_value;
          MODE_EVAL:  pending_interp.push_back(evaluate_spline(in_mon.data_value));
          default:    ;
        endcase
      end
    end
    outstanding = pending_interp.size();
  end

endmodule

// ===== test/tb_piecewise_poly_interpolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_piecewise_poly_interpolator: top level of the interpolator testbench
// Loads full knot and coefficient tables, runs a short directed set of
// queries and table edits, then random traffic over several register
// settings with random idling on both channels. A separate checker predicts
// and compares every result; this module drives stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_piecewise_poly_interpolator;
  import ppi_pkg::*;

  localparam int CLK_HALF     = 2;
  localparam int RESET_CYCLES = 10;
  // table loads and per-phase knot layouts add about 640 beats on top
  localparam int RANDOM_ITEMS = 612;
  localparam int PHASES       = 9;
  localparam int IDLE_PCT     = 11;
  localparam int HOLD_CYCLES  = 300;
  // leave margin before register writes
  localparam int TAIL_CYCLES  = 40;
  localparam int CYCLE_LIMIT  = 500000;

  // mode 3 has no function; it must be dropped without a result
  localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;
  // register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

  // register settings per random phase: zero and oversize counts hit the clamp
  localparam int PHASE_COUNT [PHASES] = '{64, 1, 0, 2, 127, 65, 5, 33, 64};
  localparam int PHASE_ORDER [PHASES] = '{3, 0, 3, 1, 2, 3, 3, 2, 0};

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int mismatches;
  int pending;
  int cycle_count = 0;

  bit steady;     // no idling on either side while set
  bit hold_req;   // asks the receiver for one long hold-off
  int hold_left;

  // stimulus-side copy of the knots, only used to aim queries
  logic signed [DATA_W-1:0] knot_shadow [MAX_KNOTS];

  ppi_in_if  req_ch ();
  ppi_out_if res_ch ();

  piecewise_poly_interpolator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_ch),
    .out_ch    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  ppi_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (req_ch),
    .out_mon        (res_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatches),
    .outstanding    (pending)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  // hard stop on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random back-pressure plus one long hold-off on request
  initial begin
    res_ch.ready = 1'b0;
    hold_left    = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  function automatic logic signed [DATA_W-1:0] to_q16(longint v);
    if (v > longint'(Q_MAX))
      return Q_MAX;
    if (v < longint'(Q_MIN))
      return Q_MIN;
    return v[DATA_W-1:0];
  endfunction

  // coefficients: many within +-2.0, some full range, some extremes
  function automatic logic signed [DATA_W-1:0] random_coeff();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35)
      return $urandom;
    if (r < 75)
      return to_q16(longint'($urandom_range(0, 1 << 18)) - (1 << 17));
    if (r < 85) begin
      case ($urandom_range(0, 3))
        0:       return Q_MAX;
        1:       return Q_MIN;
        2:       return '0;
        default: return '1;
      endcase
    end
    return to_q16(longint'($urandom_range(0, 1 << 25)) - (1 << 24));
  endfunction

  // queries: mostly inside the active span so the search and Horner steps run
  function automatic logic signed [DATA_W-1:0] pick_query(int n);
    longint          lo, hi, span;
    longint unsigned r64;
    int              r;
    lo = knot_shadow[0];
    hi = knot_shadow[n-1];
    r  = $urandom_range(0, 99);
    if (r < 10)
      return $urandom;
    if (r < 22)
      return to_q16(lo - 1 - longint'($urandom_range(0, 1 << 16)));
    if (r < 34)
      return to_q16(hi + 1 + longint'($urandom_range(0, 1 << 16)));
    if (r < 48)
      return knot_shadow[$urandom_range(0, n - 1)];
    if (hi < lo)
      return $urandom;
    span = hi - lo + 1;
    r64  = {$urandom, $urandom};
    return to_q16(lo + longint'(r64 % longint'(span)));
  endfunction

  // one request beat; valid stays up across back-to-back beats
  task automatic put_beat(input logic [MODE_W-1:0] op, input logic [ROW_W-1:0] row,
                          input logic [CSLOT_W-1:0] slot,
                          input logic signed [DATA_W-1:0] value);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.mode       <= op;
    req_ch.row_index  <= row;
    req_ch.coeff_slot <= slot;
    req_ch.data_value <= value;
    @(posedge clk);
    while (!req_ch.ready)
      @(posedge clk);
  endtask

  task automatic set_knot(input int k, input logic signed [DATA_W-1:0] v);
    knot_shadow[k] = v;
    put_beat(MODE_KNOT, ROW_W'(k), CSLOT_W'($urandom), v);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // drop valid, let every query drain, then allow the tail latency
  task automatic settle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  // ascending knots 0..n-1; wide spreads them over the whole signed range
  task automatic lay_knots(input int n, input bit wide);
    longint pos;
    pos = -(longint'(1) << 26) + longint'($urandom_range(0, 1 << 20));
    for (int k = 0; k < n; k++) begin
      if (wide && n > 1)
        pos = longint'(Q_MIN) + (longint'(k) * 64'sh0_FFFF_FFFF) / (n - 1);
      set_knot(k, to_q16(pos));
      if (!wide)
        pos += longint'($urandom_range(1, 1 << 22));
    end
  endtask

  task automatic random_item(input int n);
    int                       r, k;
    logic signed [DATA_W-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 58) begin
      put_beat(MODE_EVAL, ROW_W'($urandom), CSLOT_W'($urandom), pick_query(n));
    end else if (r < 86) begin
      k = ($urandom_range(0, 4) != 0) ? $urandom_range(0, n - 1) : $urandom_range(0, 63);
      put_beat(MODE_COEFF, ROW_W'(k), CSLOT_W'($urandom), random_coeff());
    end else if (r < 97) begin
      // knot nudges keep order mostly; full random values break it
      k = ($urandom_range(0, 4) != 0) ? $urandom_range(0, n - 1) : $urandom_range(0, 63);
      if ($urandom_range(0, 3) != 0)
        v = to_q16(longint'(knot_shadow[k]) + longint'($urandom_range(0, 8192)) - 4096);
      else
        v = $urandom;
      set_knot(k, v);
    end else begin
      put_beat(MODE_UNUSED, ROW_W'($urandom), CSLOT_W'($urandom), $urandom);
    end
  endtask

  initial begin : stimulus
    int n_eff;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    req_ch.valid      = 1'b0;
    req_ch.mode       = '0;
    req_ch.row_index  = '0;
    req_ch.coeff_slot = '0;
    req_ch.data_value = '0;
    steady            = 1'b0;
    hold_req          = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // full tables up front, so no query ever reads an unwritten entry
    write_reg(CFG_KNOT_COUNT, CFG_DATA_W'(MAX_KNOTS));
    write_reg(CFG_POLY_ORDER, CFG_DATA_W'(MAX_ORDER));
    lay_knots(MAX_KNOTS, 1'b0);
    for (int row = 0; row < MAX_KNOTS; row++)
      for (int s = 0; s < ROW_LEN; s++)
        put_beat(MODE_COEFF, ROW_W'(row), CSLOT_W'(s), random_coeff());

    // directed: span edges, exact knots, unused mode
    put_beat(MODE_EVAL, '0, '0, to_q16(longint'(knot_shadow[0]) - 1));
    put_beat(MODE_EVAL, '0, '0, to_q16(longint'(knot_shadow[MAX_KNOTS-1]) + 1));
    put_beat(MODE_EVAL, '0, '0, knot_shadow[0]);
    put_beat(MODE_EVAL, '0, '0, knot_shadow[MAX_KNOTS-1]);
    put_beat(MODE_EVAL, '0, '0, knot_shadow[17]);
    put_beat(MODE_EVAL, '0, '0,
             to_q16((longint'(knot_shadow[17]) + longint'(knot_shadow[18])) / 2));
    put_beat(MODE_UNUSED, '1, '1, $urandom);

    // extremes: span covers the full range, rows at the saturation limits
    set_knot(0, Q_MIN);
    set_knot(MAX_KNOTS - 1, Q_MAX);
    for (int s = 0; s < ROW_LEN; s++)
      put_beat(MODE_COEFF, ROW_W'(0), CSLOT_W'(s), (s % 2 != 0) ? Q_MIN : Q_MAX);
    for (int s = 0; s < ROW_LEN; s++)
      put_beat(MODE_COEFF, ROW_W'(MAX_KNOTS - 2), CSLOT_W'(s), Q_MAX);
    put_beat(MODE_EVAL, '0, '0, Q_MIN);
    put_beat(MODE_EVAL, '0, '0, Q_MIN + 1);
    put_beat(MODE_EVAL, '0, '0, Q_MAX);
    put_beat(MODE_EVAL, '0, '0, Q_MAX - 1);

    // out-of-order knot: a query just above knot 29 lands on the misplaced knot 30
    set_knot(30, knot_shadow[10]);
    put_beat(MODE_EVAL, '0, '0, to_q16(longint'(knot_shadow[29]) + 1));

    // random traffic, one register setting per phase
    for (int p = 0; p < PHASES; p++) begin
      settle();
      steady = (p == 3);
      if (p == 5) begin
        write_reg(CFG_SPARE_2, '1);
        write_reg(CFG_SPARE_3, CFG_DATA_W'(7'h2A));
      end
      write_reg(CFG_KNOT_COUNT, CFG_DATA_W'(PHASE_COUNT[p]));
      // upper data bits are junk for the order register
      write_reg(CFG_POLY_ORDER,
                CFG_DATA_W'(($urandom_range(0, 31) << ORDER_W) | PHASE_ORDER[p]));
      n_eff = (PHASE_COUNT[p] < 1) ? 1 :
              (PHASE_COUNT[p] > MAX_KNOTS) ? MAX_KNOTS : PHASE_COUNT[p];
      lay_knots(n_eff, p == 4 || p == 8);
      for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
        // long result hold-off while requests keep coming: fills the block
        if (p == 0 && i == 40)
          hold_req = 1'b1;
        random_item(n_eff);
      end
    end

    settle();
    if (mismatches == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
